[src/ccr_pkg.sv]
package ccr_pkg;

  // Default number of entries in the sort buffer.
  localparam int unsigned BufferDepth = 32;

  // Largest payload length that is stored or emitted.
  localparam int unsigned PayloadBytes = 4;

  // Type tag of a Unicode code point.
  localparam logic [7:0] TypeUnicode = 8'h01;

  // Function codes of an input item.
  localparam logic FuncChar  = 1'b0;
  localparam logic FuncFlush = 1'b1;

  // One buffered character.
  typedef struct packed {
    logic [7:0]  item_type;
    logic [31:0] payload;
    logic [2:0]  len;
    logic [7:0]  cls;
  } entry_t;

  // One result as it goes into the output register.
  typedef struct packed {
    entry_t ent;
    logic   last;
  } result_t;

  typedef enum logic [2:0] {
    StIdle,
    StDrainRd,
    StDrainOut,
    StEmit,
    StInsStart,
    StInsCmp,
    StInsWr
  } state_e;

  // What follows once the buffer has been drained.
  typedef enum logic [1:0] {
    ModeFlush,
    ModeStarter,
    ModeInsert
  } mode_e;

  function automatic logic [2:0] clamp_len(input logic [2:0] len);
    logic [2:0] res;
    if ({1'b0, len} > 4'(PayloadBytes)) begin
      res = 3'(PayloadBytes);
    end else begin
      res = len;
    end
    return res;
  endfunction

endpackage

[src/canonical_combining_reorder.sv]
// A non-starter is written straight into an empty buffer; otherwise the buffered
//   entries of higher class are moved up one at a time before it is written, and a
//   full buffer is drained first. A starter or flush drains the buffered entries,
//   then a starter is emitted after them. One item is handled at a time: the next
//   one is taken only once the sequencer is back in idle.
// Reset (rst_ni, asynchronous, active low) empties the buffer and output register.
module canonical_combining_reorder #(
  parameter int unsigned BUFFER_DEPTH = ccr_pkg::BufferDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [7:0]  item_type_i,
  input  logic [31:0] payload_i,
  input  logic [2:0]  payload_len_i,
  input  logic [7:0]  comb_class_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_type_o,
  output logic [31:0] out_payload_o,
  output logic [2:0]  out_len_o,
  output logic        last_o
);

  // The sort buffer is a single-port-write, registered-read memory. The
  // sequencer walks it one entry per step: an insert reads the entry below
  // the free slot, compares classes in the shared comparator and moves the
  // entry up while its class is strictly higher, which keeps equal classes
  // in arrival order. A drain reads the entries from the bottom up and
  // hands each to the output register, waiting while it is not free; each
  // result takes a registered memory read step and then an output step.

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  ccr_pkg::entry_t  wr_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  ccr_pkg::entry_t  rd_data;

  logic             out_free;
  logic             out_load;
  ccr_pkg::result_t out_data;

  // Output register; it frees in the same cycle as its item is taken.
  logic             out_valid_q;
  ccr_pkg::result_t out_q;

  assign out_free = !out_valid_q || out_ready_i;

  ccr_ctrl #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .item_type_i   (item_type_i),
    .payload_i     (payload_i),
    .payload_len_i (payload_len_i),
    .comb_class_i  (comb_class_i),
    .out_free_i    (out_free),
    .out_load_o    (out_load),
    .out_data_o    (out_data),
    .wr_en_o       (wr_en),
    .wr_addr_o     (wr_addr),
    .wr_data_o     (wr_data),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .rd_data_i     (rd_data)
  );

  ccr_buf #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_buf (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_data;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_type_o    = out_q.ent.item_type;
  assign out_payload_o = out_q.ent.payload;
  assign out_len_o     = out_q.ent.len;
  assign last_o        = out_q.last;

endmodule

[src/ccr_buf.sv]
module ccr_buf #(
  parameter int unsigned BUFFER_DEPTH = ccr_pkg::BufferDepth,
  localparam int unsigned AW = $clog2(BUFFER_DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  ccr_pkg::entry_t  wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output ccr_pkg::entry_t  rd_data_o
);

  // Sort buffer storage, one write and one registered read per cycle.
  ccr_pkg::entry_t mem_q [BUFFER_DEPTH];
  ccr_pkg::entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[src/ccr_ctrl.sv]
module ccr_ctrl #(
  parameter int unsigned BUFFER_DEPTH = ccr_pkg::BufferDepth,
  localparam int unsigned AW = $clog2(BUFFER_DEPTH),
  localparam int unsigned FW = $clog2(BUFFER_DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Input item
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             func_i,
  input  logic [7:0]       item_type_i,
  input  logic [31:0]      payload_i,
  input  logic [2:0]       payload_len_i,
  input  logic [7:0]       comb_class_i,
  // Output register
  input  logic             out_free_i,
  output logic             out_load_o,
  output ccr_pkg::result_t out_data_o,
  // Sort buffer
  output logic             wr_en_o,
  output logic [AW-1:0]    wr_addr_o,
  output ccr_pkg::entry_t  wr_data_o,
  output logic             rd_en_o,
  output logic [AW-1:0]    rd_addr_o,
  input  ccr_pkg::entry_t  rd_data_i
);

  ccr_pkg::state_e state_q, state_d;
  ccr_pkg::mode_e  mode_q, mode_d;
  ccr_pkg::entry_t item_q, item_d;
  logic [FW-1:0]   fill_q, fill_d;
  logic [FW-1:0]   idx_q, idx_d;

  ccr_pkg::entry_t in_entry;
  logic            accept;
  logic            in_starter;
  logic            buf_full;
  logic            buf_empty;
  logic            shift_up;
  logic [FW-1:0]   idx_dec;
  logic [FW-1:0]   idx_dec2;
  logic [FW-1:0]   idx_inc;
  logic [FW-1:0]   fill_dec;
  logic            drain_end;

  always_comb begin
    in_entry.item_type = item_type_i;
    in_entry.payload   = payload_i;
    in_entry.len       = ccr_pkg::clamp_len(payload_len_i);
    in_entry.cls       = (item_type_i == ccr_pkg::TypeUnicode) ? comb_class_i : 8'd0;
  end

  assign accept     = in_valid_i && in_ready_o;
  assign in_starter = (in_entry.cls == 8'd0);
  assign buf_full   = (fill_q == FW'(BUFFER_DEPTH));
  assign buf_empty  = (fill_q == '0);

  // Shared step unit: the class compare and the index arithmetic.
  assign shift_up  = (rd_data_i.cls > item_q.cls);
  assign idx_dec   = idx_q - FW'(1);
  assign idx_dec2  = idx_q - FW'(2);
  assign idx_inc   = idx_q + FW'(1);
  assign fill_dec  = fill_q - FW'(1);
  assign drain_end = (idx_q == fill_dec);

  // Next state
  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    item_d  = item_q;
    fill_d  = fill_q;
    idx_d   = idx_q;
    unique case (state_q)
      ccr_pkg::StIdle: begin
        if (accept) begin
          item_d = in_entry;
          idx_d  = '0;
          if (func_i == ccr_pkg::FuncFlush) begin
            mode_d  = ccr_pkg::ModeFlush;
            state_d = buf_empty ? ccr_pkg::StIdle : ccr_pkg::StDrainRd;
          end else if (in_starter) begin
            mode_d  = ccr_pkg::ModeStarter;
            state_d = buf_empty ? ccr_pkg::StEmit : ccr_pkg::StDrainRd;
          end else begin
            mode_d  = ccr_pkg::ModeInsert;
            state_d = buf_full ? ccr_pkg::StDrainRd : ccr_pkg::StInsStart;
          end
        end
      end
      ccr_pkg::StDrainRd: begin
        state_d = ccr_pkg::StDrainOut;
      end
      ccr_pkg::StDrainOut: begin
        if (out_free_i) begin
          if (drain_end) begin
            fill_d = '0;
            idx_d  = '0;
            unique case (mode_q)
              ccr_pkg::ModeStarter: state_d = ccr_pkg::StEmit;
              ccr_pkg::ModeInsert:  state_d = ccr_pkg::StInsStart;
              default:              state_d = ccr_pkg::StIdle;
            endcase
          end else begin
            idx_d   = idx_inc;
            state_d = ccr_pkg::StDrainRd;
          end
        end
      end
      ccr_pkg::StEmit: begin
        if (out_free_i) begin
          state_d = ccr_pkg::StIdle;
        end
      end
      ccr_pkg::StInsStart: begin
        if (buf_empty) begin
          fill_d  = FW'(1);
          state_d = ccr_pkg::StIdle;
        end else begin
          idx_d   = fill_q;
          state_d = ccr_pkg::StInsCmp;
        end
      end
      ccr_pkg::StInsCmp: begin
        if (shift_up) begin
          idx_d   = idx_dec;
          state_d = (idx_dec == '0) ? ccr_pkg::StInsWr : ccr_pkg::StInsCmp;
        end else begin
          fill_d  = fill_q + FW'(1);
          state_d = ccr_pkg::StIdle;
        end
      end
      ccr_pkg::StInsWr: begin
        fill_d  = fill_q + FW'(1);
        state_d = ccr_pkg::StIdle;
      end
      default: begin
        state_d = ccr_pkg::StIdle;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    out_data_o = '0;
    wr_en_o    = 1'b0;
    wr_addr_o  = idx_q[AW-1:0];
    wr_data_o  = item_q;
    rd_en_o    = 1'b0;
    rd_addr_o  = idx_q[AW-1:0];
    unique case (state_q)
      ccr_pkg::StIdle: begin
        in_ready_o = 1'b1;
      end
      ccr_pkg::StDrainRd: begin
        rd_en_o = 1'b1;
      end
      ccr_pkg::StDrainOut: begin
        out_load_o      = out_free_i;
        out_data_o.ent  = rd_data_i;
        out_data_o.last = drain_end && (mode_q != ccr_pkg::ModeStarter);
      end
      ccr_pkg::StEmit: begin
        out_load_o      = out_free_i;
        out_data_o.ent  = item_q;
        out_data_o.last = 1'b1;
      end
      ccr_pkg::StInsStart: begin
        if (buf_empty) begin
          wr_en_o   = 1'b1;
          wr_addr_o = '0;
        end else begin
          rd_en_o   = 1'b1;
          rd_addr_o = fill_dec[AW-1:0];
        end
      end
      ccr_pkg::StInsCmp: begin
        wr_en_o = 1'b1;
        if (shift_up) begin
          wr_data_o = rd_data_i;
          rd_en_o   = (idx_dec != '0);
          rd_addr_o = idx_dec2[AW-1:0];
        end
      end
      ccr_pkg::StInsWr: begin
        wr_en_o = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ccr_pkg::StIdle;
      mode_q  <= ccr_pkg::ModeFlush;
      fill_q  <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      fill_q  <= fill_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(BUFFER_DEPTH))
    else $error("fill count beyond buffer depth");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load_o |-> out_free_i)
    else $error("output register overwritten");

  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ccr_pkg::StDrainOut) |-> (fill_q != '0) && (idx_q < fill_q))
    else $error("drain index outside the filled part");

  a_cmp_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ccr_pkg::StInsCmp) |-> (idx_q != '0) && (fill_q < FW'(BUFFER_DEPTH)))
    else $error("insert position out of range");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ccr_pkg::StInsWr) |=> (fill_q == $past(fill_q) + FW'(1)))
    else $error("insert did not add one entry");

endmodule

[tb/ccr_order_check.sv]
`timescale 1ns / 1ps

module ccr_order_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        func_i,
  input  logic [7:0]  item_type_i,
  input  logic [31:0] payload_i,
  input  logic [2:0]  payload_len_i,
  input  logic [7:0]  comb_class_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  out_type_i,
  input  logic [31:0] out_payload_i,
  input  logic [2:0]  out_len_i,
  input  logic        last_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned items_o,
  output int unsigned results_o,
  output int unsigned full_drains_o,
  output int unsigned flushes_o
);

  localparam int unsigned ReportLimit = 60;

  typedef struct packed {
    logic [7:0]  tag;
    logic [31:0] payload;
    logic [2:0]  len;
    logic        last;
  } emit_t;

  ccr_pkg::entry_t sorted_run [ccr_pkg::BufferDepth];
  int unsigned     run_len = 0;
  emit_t           emit_q [$];

  int unsigned fail_count  = 0;
  int unsigned pending     = 0;
  int unsigned items       = 0;
  int unsigned results     = 0;
  int unsigned full_drains = 0;
  int unsigned flushes     = 0;

  assign fail_count_o  = fail_count;
  assign pending_o     = pending;
  assign items_o       = items;
  assign results_o     = results;
  assign full_drains_o = full_drains;
  assign flushes_o     = flushes;

  task automatic flag_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    fail_count++;
    if (fail_count <= ReportLimit) begin
      $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
    end else if (fail_count == ReportLimit + 1) begin
      $display("Further mismatches are counted but not printed.");
    end
  endtask

  // Emits the held non-starters in their sorted order and empties the run.
  task automatic drain_run(input bit mark_last);
    emit_t e;
    for (int unsigned i = 0; i < run_len; i++) begin
      e.tag     = sorted_run[i].item_type;
      e.payload = sorted_run[i].payload;
      e.len     = sorted_run[i].len;
      e.last    = mark_last && (i == run_len - 1);
      emit_q.push_back(e);
    end
    run_len = 0;
  endtask

  task automatic reorder_step(input logic f, input logic [7:0] tag,
                              input logic [31:0] data, input logic [2:0] len,
                              input logic [7:0] cls);
    ccr_pkg::entry_t ent;
    emit_t           e;
    int unsigned     pos;
    ent.item_type = tag;
    ent.payload   = data;
    ent.len       = (len > 3'(ccr_pkg::PayloadBytes)) ? 3'(ccr_pkg::PayloadBytes) : len;
    ent.cls       = (tag == ccr_pkg::TypeUnicode) ? cls : 8'd0;
    if (f == ccr_pkg::FuncFlush) begin
      flushes++;
      drain_run(1'b1);
    end else if (ent.cls == 8'd0) begin
      drain_run(1'b0);
      e.tag     = ent.item_type;
      e.payload = ent.payload;
      e.len     = ent.len;
      e.last    = 1'b1;
      emit_q.push_back(e);
    end else begin
      if (run_len >= ccr_pkg::BufferDepth) begin
        full_drains++;
        drain_run(1'b1);
      end
      // Stable insert: the new mark goes after every entry of equal or lower class.
      pos = run_len;
      while (pos > 0 && sorted_run[pos-1].cls > ent.cls) begin
        sorted_run[pos] = sorted_run[pos-1];
        pos--;
      end
      sorted_run[pos] = ent;
      run_len++;
    end
  endtask

  always @(posedge clk_i) begin
    emit_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        results++;
        if (emit_q.size() == 0) begin
          fail_count++;
          if (fail_count <= ReportLimit) begin
            $error("result with nothing expected: type 0x%0h payload 0x%0h len %0d last %0b",
                   out_type_i, out_payload_i, out_len_i, last_i);
          end
        end else begin
          want = emit_q.pop_front();
          if (out_type_i !== want.tag) begin
            flag_mismatch("out_type", 32'(want.tag), 32'(out_type_i));
          end
          if (out_payload_i !== want.payload) begin
            flag_mismatch("out_payload", want.payload, out_payload_i);
          end
          if (out_len_i !== want.len) begin
            flag_mismatch("out_len", 32'(want.len), 32'(out_len_i));
          end
          if (last_i !== want.last) begin
            flag_mismatch("last", 32'(want.last), 32'(last_i));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        items++;
        reorder_step(func_i, item_type_i, payload_i, payload_len_i, comb_class_i);
      end
      pending = emit_q.size();
    end
  end

endmodule

[tb/tb_canonical_combining_reorder.sv]
`timescale 1ns / 1ps

module tb_canonical_combining_reorder;

  localparam int unsigned RandomItems = 450;
  // No idling on either side over the closing stretch of items.
  localparam int unsigned CalmTail    = 40;
  // Settling time once nothing is expected: covers the longest insert.
  localparam int unsigned SettleCycles = 100;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        func;
  logic [7:0]  item_type;
  logic [31:0] payload;
  logic [2:0]  payload_len;
  logic [7:0]  comb_class;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_type;
  logic [31:0] out_payload;
  logic [2:0]  out_len;
  logic        last;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned items_in;
  int unsigned results_out;
  int unsigned full_drains;
  int unsigned flushes;

  int unsigned random_sent;
  int unsigned idle_pct;
  bit          calm;

  canonical_combining_reorder dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .func_i        (func),
    .item_type_i   (item_type),
    .payload_i     (payload),
    .payload_len_i (payload_len),
    .comb_class_i  (comb_class),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .out_type_o    (out_type),
    .out_payload_o (out_payload),
    .out_len_o     (out_len),
    .last_o        (last)
  );

  ccr_order_check checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .func_i        (func),
    .item_type_i   (item_type),
    .payload_i     (payload),
    .payload_len_i (payload_len),
    .comb_class_i  (comb_class),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_type_i    (out_type),
    .out_payload_i (out_payload),
    .out_len_i     (out_len),
    .last_i        (last),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .items_o       (items_in),
    .results_o     (results_out),
    .full_drains_o (full_drains),
    .flushes_o     (flushes)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: stalls in bursts, with a stall rate that wanders so
  // that long stretches without any stall occur as well.
  initial begin
    int unsigned stall_pct;
    stall_pct = 10;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 63) == 0) begin
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 30);
      end
      if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Presents one item from a falling edge and holds it until it is taken. Valid is
  // left high afterwards unless an idle gap is drawn, so back-to-back items never drop it.
  task automatic offer(input logic f, input logic [7:0] tag, input logic [31:0] data,
                       input logic [2:0] len, input logic [7:0] cls);
    in_valid    <= 1'b1;
    func        <= f;
    item_type   <= tag;
    payload     <= data;
    payload_len <= len;
    comb_class  <= cls;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
  endtask

  // Classes of combining marks; common ones often, so that equal classes meet.
  function automatic logic [7:0] mark_class();
    logic [7:0] cls;
    case ($urandom_range(0, 7))
      0:       cls = 8'd230;
      1:       cls = 8'd220;
      2:       cls = 8'd1;
      3:       cls = 8'd255;
      default: cls = 8'($urandom_range(1, 255));
    endcase
    return cls;
  endfunction

  // One base character followed by a run of combining marks, sometimes closed by
  // a flush. Other types carry a random class, which the block must ignore.
  task automatic play_cluster(input int unsigned marks);
    idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
    if ($urandom_range(0, 3) == 0) begin
      offer(ccr_pkg::FuncChar, 8'($urandom_range(0, 255)), $urandom(),
            3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
    end else begin
      offer(ccr_pkg::FuncChar, ccr_pkg::TypeUnicode, $urandom(), 3'($urandom_range(0, 7)),
            8'd0);
    end
    random_sent++;
    for (int unsigned m = 0; m < marks; m++) begin
      calm = (random_sent >= RandomItems - CalmTail);
      offer(ccr_pkg::FuncChar, ccr_pkg::TypeUnicode, $urandom(), 3'($urandom_range(0, 7)),
            mark_class());
      random_sent++;
    end
    if ($urandom_range(0, 4) == 0) begin
      offer(ccr_pkg::FuncFlush, 8'($urandom_range(0, 255)), $urandom(),
            3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      random_sent++;
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    func        = ccr_pkg::FuncChar;
    item_type   = 8'd0;
    payload     = 32'd0;
    payload_len = 3'd0;
    comb_class  = 8'd0;
    calm        = 1'b0;
    idle_pct    = 0;
    random_sent = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, sent back to back.
    offer(ccr_pkg::FuncFlush, 8'h00, 32'h0000_0000, 3'd0, 8'd0);  // flush with nothing held
    offer(ccr_pkg::FuncChar, ccr_pkg::TypeUnicode, 32'h0000_0000, 3'd0, 8'd0);
    // Class ignored, length saturated.
    offer(ccr_pkg::FuncChar, 8'hFF, 32'hFFFF_FFFF, 3'd7, 8'hFF);
    offer(ccr_pkg::FuncChar, ccr_pkg::TypeUnicode, 32'h0000_0301, 3'd2, 8'd230);
    offer(ccr_pkg::FuncChar, ccr_pkg::TypeUnicode, 32'h0000_0316, 3'd2, 8'd220);
    // Ties with the first mark.
    offer(ccr_pkg::FuncChar, ccr_pkg::TypeUnicode, 32'h0000_0302, 3'd5, 8'd230);
    offer(ccr_pkg::FuncChar, ccr_pkg::TypeUnicode, 32'h0000_0334, 3'd3, 8'd1);
    offer(ccr_pkg::FuncChar, ccr_pkg::TypeUnicode, 32'h0001_D16E, 3'd4, 8'd255);
    offer(ccr_pkg::FuncChar, ccr_pkg::TypeUnicode, 32'h0000_0327, 3'd6, 8'd202);
    // Starter drains the run.
    offer(ccr_pkg::FuncChar, ccr_pkg::TypeUnicode, 32'h0000_0041, 3'd1, 8'd0);
    offer(ccr_pkg::FuncChar, ccr_pkg::TypeUnicode, 32'h0000_CC81, 3'd2, 8'd230);
    offer(ccr_pkg::FuncChar, ccr_pkg::TypeUnicode, 32'h7FFF_FFFF, 3'd4, 8'd255);
    offer(ccr_pkg::FuncChar, 8'h00, 32'h0000_1234, 3'd4, 8'h80);  // other type acts as starter
    offer(ccr_pkg::FuncChar, ccr_pkg::TypeUnicode, 32'hAAAA_5555, 3'd3, 8'hFE);
    offer(ccr_pkg::FuncChar, ccr_pkg::TypeUnicode, 32'h5555_AAAA, 3'd1, 8'd1);
    offer(ccr_pkg::FuncFlush, 8'hFF, 32'hFFFF_FFFF, 3'd7, 8'hFF); // flush drains two marks
    offer(ccr_pkg::FuncFlush, ccr_pkg::TypeUnicode, 32'h0000_0000, 3'd0, 8'd230);
    offer(ccr_pkg::FuncChar, 8'h02, 32'h0102_0304, 3'd4, 8'd0);
    offer(ccr_pkg::FuncChar, ccr_pkg::TypeUnicode, 32'h8000_0001, 3'd4, 8'd0);

    // Hold off until every result of the directed part has been taken.
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);

    // Random part: the first cluster overfills the buffer for certain.
    play_cluster(33);
    while (random_sent < RandomItems) begin
      calm = (random_sent >= RandomItems - CalmTail);
      if ($urandom_range(0, 9) == 0) begin
        offer(logic'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), $urandom(),
              3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
        random_sent++;
      end else if ($urandom_range(0, 11) == 0) begin
        play_cluster($urandom_range(32, 36));
      end else begin
        play_cluster($urandom_range(0, 6));
      end
    end
    // A closing flush so that nothing is left in the buffer unchecked.
    offer(ccr_pkg::FuncFlush, 8'h00, 32'h0000_0000, 3'd0, 8'd0);
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);

    $display("Summary: %0d items accepted and %0d results compared,", items_in, results_out);
    $display("  including %0d drains of a full buffer and %0d flush commands.",
             full_drains, flushes);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(30_000_000);
    $display("Timeout with %0d results still expected.", pending);
    $display("TB_ERROR");
    $finish;
  end

endmodule

[canonical_combining_reorder.f]
src/ccr_pkg.sv
src/ccr_buf.sv
src/ccr_ctrl.sv
src/canonical_combining_reorder.sv
tb/ccr_order_check.sv
tb/tb_canonical_combining_reorder.sv
